[rtl/core/connected_component_labeling_defines.svh]
// Assertion macros shared by the connected component labeling RTL.
// No dependencies; included by ccl_back, the only module that carries assertions.
`ifndef CONNECTED_COMPONENT_LABELING_DEFINES_SVH
`define CONNECTED_COMPONENT_LABELING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("connected component labeling check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("connected component labeling check failed");

`endif

[rtl/core/ccl_pkg.sv]
// Shared types and constants for the connected component labeling block.
// No dependencies; imported by every module of the block.
package ccl_pkg;

	localparam int RowW       = 32;
	localparam int NodeCountW = 6;
	localparam int VertexW    = 5;
	localparam int LabelW     = 5;
	localparam int CountW     = 6;

	localparam logic [NodeCountW-1:0] NodeCountReset = 6'd32;
	localparam logic [NodeCountW-1:0] RowsLoadedMax  = 6'd63;

	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);

	// One classified row on its way from the front end to the labeling engine.
	typedef struct packed {
		logic [RowW-1:0]       row;
		logic [NodeCountW-1:0] idx;
		logic                  store;
		logic                  last;
		logic [NodeCountW-1:0] n;
	} ccl_row_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROOT,
		ST_EXPAND,
		ST_MERGE,
		ST_READ,
		ST_SHOW
	} ccl_state_t;

endpackage

[rtl/core/ccl_front.sv]
// Front end: node count register, row counter and row classification.
// Depends on ccl_pkg.
module ccl_front #(
	parameter int MAX_NODES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ccl_pkg::NodeCountW-1:0]    cfg_wdata,
	input  logic                              row_valid,
	output logic                              row_stall,
	input  logic [ccl_pkg::RowW-1:0]          row_edges,
	output logic                              push_valid,
	input  logic                              push_stall,
	output ccl_pkg::ccl_row_t                 push_entry
);
	import ccl_pkg::*;

	logic [NodeCountW-1:0] node_count_q;
	logic [NodeCountW-1:0] rows_q;
	logic [NodeCountW-1:0] rows_inc;
	logic [NodeCountW-1:0] n_eff;
	logic                  fin;
	logic                  accept;

	// Effective vertex count: zero counts as one, large values saturate.
	always_comb begin
		n_eff = node_count_q;
		if (node_count_q == '0) begin
			n_eff = NodeCountW'(1);
		end else if (int'(node_count_q) > MAX_NODES) begin
			n_eff = NodeCountW'(MAX_NODES);
		end
	end

	assign rows_inc = (rows_q != RowsLoadedMax) ? rows_q + NodeCountW'(1) : rows_q;
	assign fin      = rows_inc >= n_eff;
	assign accept   = row_valid && !row_stall;

	assign row_stall  = push_stall;
	assign push_valid = row_valid;

	always_comb begin
		push_entry.row   = row_edges;
		push_entry.idx   = rows_q;
		push_entry.store = int'(rows_q) < MAX_NODES;
		push_entry.last  = fin;
		push_entry.n     = n_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NodeCountReset;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
		end else if (accept) begin
			rows_q <= fin ? '0 : rows_inc;
		end
	end

endmodule

[rtl/core/ccl_fifo.sv]
// Short queue of classified rows between the front end and the engine.
// Depends on ccl_pkg.
module ccl_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_stall,
	input  ccl_pkg::ccl_row_t push_entry,
	output logic              pop_valid,
	input  logic              pop_stall,
	output ccl_pkg::ccl_row_t pop_entry
);
	import ccl_pkg::*;

	ccl_row_t           slots_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QPtrW:0]     fill_q;
	logic               push;
	logic               pop;

	assign push_stall = fill_q == (QPtrW + 1)'(QDepth);
	assign pop_valid  = fill_q != '0;
	assign pop_entry  = slots_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPtrW + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPtrW + 1)'(1);
			end
		end
	end

endmodule

[rtl/core/ccl_back.sv]
// Labeling engine: adjacency and label memories, component walk, result output.
// Depends on ccl_pkg and connected_component_labeling_defines.svh.
`include "connected_component_labeling_defines.svh"

module ccl_back #(
	parameter int MAX_NODES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_stall,
	input  ccl_pkg::ccl_row_t              q_entry,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [ccl_pkg::VertexW-1:0]    vertex,
	output logic [ccl_pkg::LabelW-1:0]     label,
	output logic                           is_last,
	output logic [ccl_pkg::CountW-1:0]     component_count
);
	import ccl_pkg::*;

	localparam int NW = MAX_NODES;
	localparam int VW = $clog2(MAX_NODES);

	logic [RowW-1:0]   adj_mem [MAX_NODES];
	logic [LabelW-1:0] lab_mem [MAX_NODES];

	ccl_state_t            st_q;
	ccl_state_t            st_d;
	logic [NodeCountW-1:0] n_q;
	logic [NW-1:0]         visited_q;
	logic [NW-1:0]         comp_q;
	logic [NW-1:0]         pending_q;
	logic [CountW-1:0]     count_q;
	logic [VW-1:0]         v_q;
	logic [RowW-1:0]       adj_rd_q;
	logic [LabelW-1:0]     lab_rd_q;

	logic [NW-1:0] nmask;
	logic [NW-1:0] unv;
	logic [NW-1:0] fresh;
	logic [VW-1:0] root_idx;
	logic [VW-1:0] pend_idx;
	logic          q_pop;
	logic          last_v;

	assign q_stall   = st_q != ST_LOAD;
	assign q_pop     = q_valid && !q_stall;
	assign res_valid = st_q == ST_SHOW;

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			nmask[i] = (NodeCountW + 1)'(i) < {1'b0, n_q};
		end
	end

	assign unv   = ~visited_q & nmask;
	assign fresh = NW'(adj_rd_q) & nmask & ~visited_q & ~comp_q;

	// Lowest set bit of the unvisited set and of the pending set.
	always_comb begin
		root_idx = '0;
		pend_idx = '0;
		for (int i = NW - 1; i >= 0; i--) begin
			if (unv[i]) begin
				root_idx = VW'(i);
			end
			if (pending_q[i]) begin
				pend_idx = VW'(i);
			end
		end
	end

	assign last_v = ((NodeCountW + 1)'(v_q) + (NodeCountW + 1)'(1)) == {1'b0, n_q};

	assign vertex          = VertexW'(v_q);
	assign label           = lab_rd_q;
	assign is_last         = last_v;
	assign component_count = last_v ? count_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD: begin
				if (q_pop && q_entry.last) begin
					st_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				st_d = (unv == '0) ? ST_READ : ST_EXPAND;
			end
			ST_EXPAND: begin
				st_d = ST_MERGE;
			end
			ST_MERGE: begin
				st_d = ((pending_q | fresh) == '0) ? ST_ROOT : ST_EXPAND;
			end
			ST_READ: begin
				st_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (!res_stall) begin
					st_d = last_v ? ST_LOAD : ST_READ;
				end
			end
			default: begin
				st_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			visited_q <= '0;
			comp_q    <= '0;
			pending_q <= '0;
			count_q   <= '0;
			v_q       <= '0;
		end else begin
			case (st_q)
				ST_LOAD: begin
					if (q_pop && q_entry.last) begin
						n_q       <= q_entry.n;
						visited_q <= '0;
						count_q   <= '0;
						v_q       <= '0;
					end
				end
				ST_ROOT: begin
					if (unv != '0) begin
						comp_q    <= NW'(1) << root_idx;
						pending_q <= NW'(1) << root_idx;
					end
				end
				ST_EXPAND: begin
					pending_q <= pending_q & ~(NW'(1) << pend_idx);
				end
				ST_MERGE: begin
					comp_q    <= comp_q | fresh;
					pending_q <= pending_q | fresh;
					if ((pending_q | fresh) == '0) begin
						visited_q <= visited_q | comp_q;
						count_q   <= count_q + CountW'(1);
					end
				end
				ST_SHOW: begin
					if (!res_stall && !last_v) begin
						v_q <= v_q + VW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD && q_pop && q_entry.store) begin
			adj_mem[q_entry.idx[VW-1:0]] <= q_entry.row;
		end
		if (st_q == ST_EXPAND) begin
			adj_rd_q <= adj_mem[pend_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_EXPAND) begin
			lab_mem[pend_idx] <= count_q[LabelW-1:0];
		end
		if (st_q == ST_READ) begin
			lab_rd_q <= lab_mem[v_q];
		end
	end

	`CCL_ASSERT_IMP(a_expand_has_work, clk, arst_n, st_q == ST_EXPAND, pending_q != '0 && (pending_q & ~comp_q) == '0)
	`CCL_ASSERT_IMP(a_comp_unvisited, clk, arst_n, st_q == ST_EXPAND || st_q == ST_MERGE, (comp_q & visited_q) == '0)
	`CCL_ASSERT_IMP(a_count_bounded, clk, arst_n, st_q == ST_SHOW, count_q != '0 && count_q <= n_q)
	`CCL_ASSERT_IMP(a_all_labeled, clk, arst_n, st_q == ST_SHOW, visited_q == nmask)

endmodule

[rtl/core/connected_component_labeling.sv]
// Top level of the connected component labeling block.
// Depends on ccl_pkg, ccl_front, ccl_fifo and ccl_back.
//
//   Channel   Handshake                 Payload
//   rows      row_valid / row_stall     row_edges
//   results   res_valid / res_stall     vertex, label, is_last, component_count
//   config    cfg_we                    cfg_wdata (node_count)
//
// Each row is registered in the queue before the engine sees it.
// After the last row, labeling passes the root state once per component, the expand and
// merge states for each vertex walked (one adjacency memory read each) and a closing root
// state; each result is then read from the label memory and shown.
// Reset clears all control state; the adjacency and label memories are not cleared.
// A stalled result holds the engine; the row side stalls only when the queue fills.
module connected_component_labeling #(
	parameter int MAX_NODES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ccl_pkg::NodeCountW-1:0]    cfg_wdata,
	input  logic                              row_valid,
	output logic                              row_stall,
	input  logic [ccl_pkg::RowW-1:0]          row_edges,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [ccl_pkg::VertexW-1:0]       vertex,
	output logic [ccl_pkg::LabelW-1:0]        label,
	output logic                              is_last,
	output logic [ccl_pkg::CountW-1:0]        component_count
);
	import ccl_pkg::*;

	// Classified rows travel from the front end through the queue.
	ccl_row_t push_entry;
	ccl_row_t pop_entry;
	logic     push_valid;
	logic     push_stall;
	logic     pop_valid;
	logic     pop_stall;

	// The front end owns the node count register and the row counter. It
	// tags each row with its index, whether it is stored, and whether it
	// completes the graph, so the engine never looks at the configuration.
	ccl_front #(
		.MAX_NODES(MAX_NODES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.row_edges (row_edges),
		.push_valid(push_valid),
		.push_stall(push_stall),
		.push_entry(push_entry)
	);

	// A short queue lets rows of the next graph transfer in while the
	// engine is still labeling and reporting the current one.
	ccl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_stall(push_stall),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_stall (pop_stall),
		.pop_entry (pop_entry)
	);

	// The engine stores rows, walks each component from its lowest
	// unvisited vertex, and reports one label per vertex in vertex order.
	ccl_back #(
		.MAX_NODES(MAX_NODES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (pop_valid),
		.q_stall        (pop_stall),
		.q_entry        (pop_entry),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.vertex         (vertex),
		.label          (label),
		.is_last        (is_last),
		.component_count(component_count)
	);

endmodule
